>>> rtl/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg: shared constants and types for the RGB to HSV converter
// Component and fraction widths, stream packing and the divider payload.
// ----------------------------------------------------------------------------
package rth_pkg;

    localparam int COMP_BITS  = 8;
    localparam int FRAC_BITS  = 16;

    // 6 * max component fits in three extra bits
    localparam int DEN_W      = COMP_BITS + 3;

    localparam int IN_USED_W  = 3 * COMP_BITS;
    localparam int OUT_USED_W = 2 * FRAC_BITS + COMP_BITS;
    localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    // Payload carried through the divider stages
    typedef struct packed {
        logic [DEN_W-1:0]     den_h;   // 6 * delta
        logic [DEN_W-1:0]     rem_h;   // hue partial remainder
        logic [COMP_BITS-1:0] rem_s;   // saturation partial remainder
        logic [FRAC_BITS-1:0] q_h;     // hue quotient bits so far
        logic [FRAC_BITS-1:0] q_s;     // saturation quotient bits so far
        logic [COMP_BITS-1:0] value;   // max component, also saturation divisor
        logic                 zero;    // grey or black: hue and saturation are zero
    } t_div_data;

endpackage

>>> rtl/rth_prep.sv
// ----------------------------------------------------------------------------
// rth_prep: first pipeline stage of the RGB to HSV converter
// Finds max, min and delta, picks the hue numerator by sector, registers all.
// ----------------------------------------------------------------------------
module rth_prep
    import rth_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [COMP_BITS-1:0] i_red,
    input  logic [COMP_BITS-1:0] i_green,
    input  logic [COMP_BITS-1:0] i_blue,
    output logic                 o_valid,
    output t_div_data            o_data
);

    logic [COMP_BITS-1:0] mx;
    logic [COMP_BITS-1:0] mn;
    logic [COMP_BITS-1:0] delta;
    logic [DEN_W-1:0]     d_w;
    logic [DEN_W-1:0]     r_w;
    logic [DEN_W-1:0]     g_w;
    logic [DEN_W-1:0]     b_w;
    logic [DEN_W-1:0]     den;
    logic [DEN_W-1:0]     num;

    logic                 r_valid;
    t_div_data            r_data;
    t_div_data            n_data;

    always_comb begin
        mx = (i_red > i_green) ? i_red : i_green;
        if (i_blue > mx) begin
            mx = i_blue;
        end
        mn = (i_red < i_green) ? i_red : i_green;
        if (i_blue < mn) begin
            mn = i_blue;
        end
        delta = mx - mn;

        d_w = DEN_W'(delta);
        r_w = DEN_W'(i_red);
        g_w = DEN_W'(i_green);
        b_w = DEN_W'(i_blue);
        den = (d_w << 2) + (d_w << 1);

        // green first, then blue, then red; every numerator lands in [0, 6d)
        if (i_green == mx) begin
            num = (d_w << 1) + b_w - r_w;
        end else if (i_blue == mx) begin
            num = (d_w << 2) + r_w - g_w;
        end else if (i_green >= i_blue) begin
            num = g_w - b_w;
        end else begin
            num = den - (b_w - g_w);
        end

        n_data       = '0;
        n_data.den_h = den;
        n_data.rem_h = num;
        // min of zero gives rem == divisor, which yields all ones: the saturated code
        n_data.rem_s = delta;
        n_data.value = mx;
        n_data.zero  = (delta == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/rth_div_step.sv
// ----------------------------------------------------------------------------
// rth_div_step: one restoring-division stage
// Produces one quotient bit each for hue and saturation and registers them.
// ----------------------------------------------------------------------------
module rth_div_step
    import rth_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_div_data i_data,
    output logic      o_valid,
    output t_div_data o_data
);

    logic [DEN_W:0]     sh_h;
    logic [DEN_W:0]     diff_h;
    logic               ge_h;
    logic [COMP_BITS:0] sh_s;
    logic [COMP_BITS:0] diff_s;
    logic               ge_s;

    logic               r_valid;
    t_div_data          r_data;
    t_div_data          n_data;

    always_comb begin
        sh_h   = {i_data.rem_h, 1'b0};
        diff_h = sh_h - {1'b0, i_data.den_h};
        ge_h   = (sh_h >= {1'b0, i_data.den_h});

        sh_s   = {i_data.rem_s, 1'b0};
        diff_s = sh_s - {1'b0, i_data.value};
        ge_s   = (sh_s >= {1'b0, i_data.value});

        n_data       = i_data;
        n_data.rem_h = ge_h ? diff_h[DEN_W-1:0] : sh_h[DEN_W-1:0];
        n_data.rem_s = ge_s ? diff_s[COMP_BITS-1:0] : sh_s[COMP_BITS-1:0];
        n_data.q_h   = {i_data.q_h[FRAC_BITS-2:0], ge_h};
        n_data.q_s   = {i_data.q_s[FRAC_BITS-2:0], ge_s};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/rgb_to_hsv.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv: pipelined RGB to HSV pixel converter
// Value is the max component; hue and saturation are 0.16 truncated fractions.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload (low bits first)
//  s         in         red, green, blue (8 bits each)
//  m         out        hue (16), saturation (16), brightness (8)
//
//  One pixel per clock sustained while the output is not stalled. The stages are:
//  one stage for max/min/sector, one restoring-division stage per fraction
//  bit, shared by hue and saturation, and the output register.
//  Each stage advances when it is empty or the next one advances, so
//  bubbles close up and a stall loses or repeats nothing.
//  Synchronous active-low reset clears all valid bits.
// ----------------------------------------------------------------------------
module rgb_to_hsv
    import rth_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // red, green, blue
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata    // hue, saturation, brightness
);

    localparam int LAST = FRAC_BITS + 1;

    logic      en    [0:LAST];
    logic      vld   [0:FRAC_BITS];
    t_div_data data  [0:FRAC_BITS];

    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic [OUT_DATA_W-1:0] n_m_data;

    // enable chain, from the output back to the input
    assign en[LAST] = !r_m_valid || i_m_tready;

    genvar k;
    generate
        for (k = 0; k < LAST; k++) begin : g_en
            assign en[k] = !vld[k] || en[k+1];
        end
    endgenerate

    assign o_s_tready = en[0];

    rth_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en[0]),
        .i_valid (i_s_tvalid),
        .i_red   (i_s_tdata[COMP_BITS-1:0]),
        .i_green (i_s_tdata[2*COMP_BITS-1:COMP_BITS]),
        .i_blue  (i_s_tdata[3*COMP_BITS-1:2*COMP_BITS]),
        .o_valid (vld[0]),
        .o_data  (data[0])
    );

    generate
        for (k = 1; k <= FRAC_BITS; k++) begin : g_div
            rth_div_step u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en[k]),
                .i_valid (vld[k-1]),
                .i_data  (data[k-1]),
                .o_valid (vld[k]),
                .o_data  (data[k])
            );
        end
    endgenerate

    always_comb begin
        n_m_data = '0;
        if (!data[FRAC_BITS].zero) begin
            n_m_data[FRAC_BITS-1:0]           = data[FRAC_BITS].q_h;
            n_m_data[2*FRAC_BITS-1:FRAC_BITS] = data[FRAC_BITS].q_s;
        end
        n_m_data[OUT_USED_W-1:2*FRAC_BITS] = data[FRAC_BITS].value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en[LAST]) begin
            r_m_valid <= vld[FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[LAST]) begin
            r_m_data <= n_m_data;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule
